### hw/rtl/hcbd_pkg.sv
`default_nettype none

package hcbd_pkg;

  // Default width of the size, length and total counters.
  localparam int COUNT_WIDTH = 32;

  // Widths fixed by the port definition.
  localparam int BYTE_WIDTH      = 8;
  localparam int TOTAL_WIDTH     = 32;
  localparam int STATUS_WIDTH    = 2;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = 32;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CHUNKED_MODE   = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CONTENT_LENGTH = 1'b1;

  // Characters the parser looks for.
  localparam logic [BYTE_WIDTH-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_WIDTH-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_WIDTH-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_WIDTH-1:0] CH_TAB   = 8'h09;

  // Parser phase.
  typedef enum logic [2:0] {
    PH_SIZE,
    PH_DATA,
    PH_DATAEND,
    PH_TRAILER,
    PH_DONE,
    PH_LEN
  } phase_t;

  // Status codes reported with each result word.
  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_AFTER_END = 2'd2
  } status_t;

endpackage

`default_nettype wire

### hw/rtl/hcbd_channels.sv
`default_nettype none

// Raw body byte channel.
interface hcbd_in_if;
  logic                              valid;
  logic                              ready;
  logic [hcbd_pkg::BYTE_WIDTH-1:0]   in_byte;
  logic                              msg_start;

  modport source (output valid, output in_byte, output msg_start, input ready);
  modport sink   (input valid, input in_byte, input msg_start, output ready);
endinterface

// Decoded result channel.
interface hcbd_out_if;
  logic                              valid;
  logic                              ready;
  logic [hcbd_pkg::BYTE_WIDTH-1:0]   out_byte;
  logic                              payload_valid;
  logic                              chunk_last;
  logic                              body_done;
  logic [hcbd_pkg::TOTAL_WIDTH-1:0]  total_bytes;
  logic [hcbd_pkg::STATUS_WIDTH-1:0] status;

  modport source (output valid, output out_byte, output payload_valid, output chunk_last,
                  output body_done, output total_bytes, output status, input ready);
  modport sink   (input valid, input out_byte, input payload_valid, input chunk_last,
                  input body_done, input total_bytes, input status, output ready);
endinterface

`default_nettype wire

### hw/rtl/http_chunked_body_decoder.sv
`default_nettype none

// Channel   Dir  Word contents
// in_ch     in   in_byte, msg_start
// out_ch    out  out_byte, payload_valid, chunk_last, body_done, total_bytes, status
// cfg_*     in   cfg_we, cfg_index, cfg_data (write only)
//
// Every accepted byte gives one result word, which is captured in the output register.
// A byte can be taken in every cycle; the parser state and the output register are
// the only stages, so throughput is one byte per clock while the sink keeps up.
// When the sink stalls, the result waits in the output register and in_ch.ready
// drops until it is taken. Synchronous reset returns the parser to the size line
// in chunked mode with all counters cleared; no memory needs clearing.

module http_chunked_body_decoder #(
  parameter int COUNT_WIDTH = hcbd_pkg::COUNT_WIDTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  hcbd_in_if.sink                                   in_ch,
  hcbd_out_if.source                                out_ch,
  input  wire logic                                 cfg_we,
  input  wire logic [hcbd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [hcbd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

  localparam int TW = hcbd_pkg::TOTAL_WIDTH;
  localparam int BW = hcbd_pkg::BYTE_WIDTH;

  // Configuration registers.
  logic                          chunked_mode;
  logic [TW-1:0]                 content_length;

  // Parser state.
  hcbd_pkg::phase_t              phase, phase_next;
  logic [COUNT_WIDTH-1:0]        size_accum, size_accum_next;
  logic [COUNT_WIDTH-1:0]        bytes_left, bytes_left_next;
  logic [COUNT_WIDTH-1:0]        body_total, body_total_next;
  logic                          prev_was_cr, prev_was_cr_next;
  logic                          digits_done, digits_done_next;
  logic                          digit_seen, digit_seen_next;

  // State as seen by the current byte, after a message start is applied.
  hcbd_pkg::phase_t              s_phase;
  logic [COUNT_WIDTH-1:0]        s_size, s_left, s_total;
  logic                          s_cr, s_dd, s_ds;

  // Output register.
  logic                          out_valid;
  logic [BW-1:0]                 out_byte;
  logic                          payload_valid, chunk_last, body_done;
  logic [TW-1:0]                 total_bytes;
  hcbd_pkg::status_t             status;

  // Per-byte decode.
  logic                          in_fire;
  logic [BW-1:0]                 b;
  logic                          line_end;
  logic                          is_hex;
  logic [3:0]                    hex_nib;
  logic                          acc_ovf;
  logic [COUNT_WIDTH:0]          total_sum;
  logic [COUNT_WIDTH-1:0]        total_add;
  logic [COUNT_WIDTH-1:0]        len_sat;
  logic                          last_byte;
  logic                          valid_c, last_c, done_c;
  hcbd_pkg::status_t             status_c;
  logic [TW-1:0]                 total_out;

  assign b        = in_ch.in_byte;
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_fire  = in_ch.valid && in_ch.ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      chunked_mode   <= 1'b1;
      content_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hcbd_pkg::REG_CHUNKED_MODE:   chunked_mode   <= cfg_data[0];
        hcbd_pkg::REG_CONTENT_LENGTH: content_length <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // Content length clipped to the counter, and the total truncated or zero-extended to the port width.
  generate
    if (COUNT_WIDTH >= TW) begin : g_wide
      assign len_sat   = COUNT_WIDTH'(content_length);
      assign total_out = body_total_next[TW-1:0];
    end else begin : g_narrow
      assign len_sat   = (|content_length[TW-1:COUNT_WIDTH]) ? '1
                                                              : content_length[COUNT_WIDTH-1:0];
      assign total_out = {{(TW-COUNT_WIDTH){1'b0}}, body_total_next};
    end
  endgenerate

  // Apply a message start before the byte is parsed.
  always_comb begin
    s_phase = phase;
    s_size  = size_accum;
    s_left  = bytes_left;
    s_total = body_total;
    s_cr    = prev_was_cr;
    s_dd    = digits_done;
    s_ds    = digit_seen;
    if (in_ch.msg_start) begin
      s_size = '0;
      s_cr   = 1'b0;
      s_dd   = 1'b0;
      s_ds   = 1'b0;
      if (chunked_mode) begin
        s_left  = '0;
        s_total = '0;
        s_phase = hcbd_pkg::PH_SIZE;
      end else begin
        s_left  = len_sat;
        s_total = len_sat;
        s_phase = (len_sat == '0) ? hcbd_pkg::PH_DONE : hcbd_pkg::PH_LEN;
      end
    end
  end

  // Hex digit decode.
  always_comb begin
    is_hex  = 1'b1;
    hex_nib = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      hex_nib = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      hex_nib = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      hex_nib = 4'(b - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign line_end  = (b == hcbd_pkg::CH_LF) && s_cr;
  assign acc_ovf   = |s_size[COUNT_WIDTH-1:COUNT_WIDTH-4];
  assign total_sum = {1'b0, s_total} + {1'b0, s_size};
  assign total_add = total_sum[COUNT_WIDTH] ? '1 : total_sum[COUNT_WIDTH-1:0];
  assign last_byte = (s_left[COUNT_WIDTH-1:1] == '0);

  // Next state.
  always_comb begin
    phase_next       = s_phase;
    size_accum_next  = s_size;
    bytes_left_next  = s_left;
    body_total_next  = s_total;
    prev_was_cr_next = s_cr;
    digits_done_next = s_dd;
    digit_seen_next  = s_ds;
    unique case (s_phase)
      hcbd_pkg::PH_SIZE: begin
        if (line_end) begin
          if (!s_ds) begin
            phase_next = hcbd_pkg::PH_DONE;
          end else if (s_size == '0) begin
            phase_next = hcbd_pkg::PH_TRAILER;
          end else begin
            bytes_left_next = s_size;
            body_total_next = total_add;
            phase_next      = hcbd_pkg::PH_DATA;
          end
          size_accum_next  = '0;
          prev_was_cr_next = 1'b0;
          digits_done_next = 1'b0;
          digit_seen_next  = 1'b0;
        end else begin
          if (is_hex && !s_dd) begin
            size_accum_next = acc_ovf ? '1 : {s_size[COUNT_WIDTH-5:0], hex_nib};
            digit_seen_next = 1'b1;
          end else if (!(!s_ds && !s_dd &&
                         (b == hcbd_pkg::CH_SPACE || b == hcbd_pkg::CH_TAB))) begin
            digits_done_next = 1'b1;
          end
          prev_was_cr_next = (b == hcbd_pkg::CH_CR);
        end
      end
      hcbd_pkg::PH_DATA, hcbd_pkg::PH_LEN: begin
        if (last_byte) begin
          bytes_left_next = '0;
          phase_next = (s_phase == hcbd_pkg::PH_LEN) ? hcbd_pkg::PH_DONE
                                                     : hcbd_pkg::PH_DATAEND;
        end else begin
          bytes_left_next = s_left - 1'b1;
        end
        prev_was_cr_next = 1'b0;
      end
      hcbd_pkg::PH_DATAEND: begin
        if (line_end) begin
          phase_next       = hcbd_pkg::PH_SIZE;
          size_accum_next  = '0;
          prev_was_cr_next = 1'b0;
          digits_done_next = 1'b0;
          digit_seen_next  = 1'b0;
        end else begin
          prev_was_cr_next = (b == hcbd_pkg::CH_CR);
        end
      end
      hcbd_pkg::PH_TRAILER: begin
        // In the trailer, digits_done marks a field line with content.
        if (line_end) begin
          if (!s_dd) begin
            phase_next = hcbd_pkg::PH_DONE;
          end
          size_accum_next  = '0;
          prev_was_cr_next = 1'b0;
          digits_done_next = 1'b0;
          digit_seen_next  = 1'b0;
        end else begin
          if (b != hcbd_pkg::CH_CR || s_cr) begin
            digits_done_next = 1'b1;
          end
          prev_was_cr_next = (b == hcbd_pkg::CH_CR);
        end
      end
      default: begin
        phase_next = hcbd_pkg::PH_DONE;
      end
    endcase
  end

  // Result word for this byte.
  always_comb begin
    valid_c  = 1'b0;
    last_c   = 1'b0;
    done_c   = 1'b0;
    status_c = hcbd_pkg::ST_OK;
    unique case (s_phase)
      hcbd_pkg::PH_SIZE: begin
        if (line_end) begin
          done_c = !s_ds;
        end else if (is_hex && !s_dd && acc_ovf) begin
          status_c = hcbd_pkg::ST_OVERFLOW;
        end
      end
      hcbd_pkg::PH_DATA, hcbd_pkg::PH_LEN: begin
        valid_c = 1'b1;
        last_c  = last_byte;
        done_c  = last_byte && (s_phase == hcbd_pkg::PH_LEN);
      end
      hcbd_pkg::PH_DATAEND: ;
      hcbd_pkg::PH_TRAILER: begin
        done_c = line_end && !s_dd;
      end
      default: begin
        done_c   = 1'b1;
        status_c = hcbd_pkg::ST_AFTER_END;
      end
    endcase
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= hcbd_pkg::PH_SIZE;
      size_accum  <= '0;
      bytes_left  <= '0;
      body_total  <= '0;
      prev_was_cr <= 1'b0;
      digits_done <= 1'b0;
      digit_seen  <= 1'b0;
    end else if (in_fire) begin
      phase       <= phase_next;
      size_accum  <= size_accum_next;
      bytes_left  <= bytes_left_next;
      body_total  <= body_total_next;
      prev_was_cr <= prev_was_cr_next;
      digits_done <= digits_done_next;
      digit_seen  <= digit_seen_next;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_byte      <= valid_c ? b : '0;
      payload_valid <= valid_c;
      chunk_last    <= last_c;
      body_done     <= done_c;
      total_bytes   <= total_out;
      status        <= status_c;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.out_byte      = out_byte;
  assign out_ch.payload_valid = payload_valid;
  assign out_ch.chunk_last    = chunk_last;
  assign out_ch.body_done     = body_done;
  assign out_ch.total_bytes   = total_bytes;
  assign out_ch.status        = status;

`ifndef SYNTHESIS
  // A payload word never carries an error status.
  a_payload_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && payload_valid |-> status == hcbd_pkg::ST_OK)
    else $error("payload word with nonzero status");

  // The end of a chunk is only marked on a payload word.
  a_last_is_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && chunk_last |-> payload_valid)
    else $error("chunk_last without payload");

  // A byte that ends the body leaves the parser in the done phase.
  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    in_fire && done_c |=> phase == hcbd_pkg::PH_DONE)
    else $error("body ended but parser not done");

  // Non-payload words carry a zero byte.
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !payload_valid |-> out_byte == '0)
    else $error("nonzero byte on non-payload word");
`endif

endmodule

`default_nettype wire

### tb/sv/tb.sv
`default_nettype none

module tb;
  import hcbd_pkg::*;

  localparam int unsigned LIMIT = 800000;
  localparam logic [63:0] CNT_MASK = (64'd1 << COUNT_WIDTH) - 64'd1;

  // One raw body byte waiting to be sent, with its start-of-body mark.
  typedef struct {
    logic [BYTE_WIDTH-1:0] data;
    logic                  start;
  } body_byte_t;

  // One decoded result word.
  typedef struct packed {
    logic [BYTE_WIDTH-1:0]  out_byte;
    logic                   payload_valid;
    logic                   chunk_last;
    logic                   body_done;
    logic [TOTAL_WIDTH-1:0] total_bytes;
    status_t                status;
  } dec_word_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0] cfg_data;

  hcbd_in_if  in_ch ();
  hcbd_out_if out_ch ();

  http_chunked_body_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  body_byte_t  raw_q[$];
  dec_word_t   decoded_q[$];
  int          err_cnt = 0;
  int unsigned pushed_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned src_gap = 0;
  int unsigned snk_gap = 0;
  bit          idle_on = 1'b1;
  bit          start_next = 1'b0;
  string       hexchars = "0123456789abcdefABCDEF";

  // Register copies as the decoder holds them.
  bit          cur_chunked;
  logic [31:0] cur_len;

  // Parser state of the predictor.
  phase_t      dec_phase;
  logic [63:0] size_acc;
  logic [63:0] left_cnt;
  logic [63:0] total_cnt;
  bit          saw_cr;
  bit          digits_end;
  bit          have_digit;

  function automatic void clear_size_line();
    size_acc   = '0;
    saw_cr     = 1'b0;
    digits_end = 1'b0;
    have_digit = 1'b0;
  endfunction

  // Advances the parser by one byte and returns the result word it gives.
  function automatic dec_word_t decode_byte(input logic [7:0] b, input logic start);
    dec_word_t   w;
    logic        line_end;
    bit          is_hex;
    logic [3:0]  nib;
    logic [63:0] len;
    w = '0;
    if (start) begin
      clear_size_line();
      left_cnt  = '0;
      total_cnt = '0;
      if (cur_chunked) begin
        dec_phase = PH_SIZE;
      end else begin
        len = {32'b0, cur_len};
        if (len > CNT_MASK) len = CNT_MASK;
        left_cnt  = len;
        total_cnt = len;
        dec_phase = (len == 0) ? PH_DONE : PH_LEN;
      end
    end

    line_end = (b == CH_LF) && saw_cr;
    is_hex = 1'b1;
    nib = '0;
    if (b >= "0" && b <= "9") nib = 4'(b - "0");
    else if (b >= "a" && b <= "f") nib = 4'(b - "a" + 10);
    else if (b >= "A" && b <= "F") nib = 4'(b - "A" + 10);
    else is_hex = 1'b0;

    case (dec_phase)
      PH_SIZE: begin
        if (line_end) begin
          if (!have_digit) begin
            dec_phase = PH_DONE;
            w.body_done = 1'b1;
          end else if (size_acc == 0) begin
            dec_phase = PH_TRAILER;
          end else begin
            left_cnt = size_acc;
            total_cnt = (total_cnt > CNT_MASK - size_acc) ? CNT_MASK : total_cnt + size_acc;
            dec_phase = PH_DATA;
          end
          clear_size_line();
        end else begin
          if (is_hex && !digits_end) begin
            if (size_acc > (CNT_MASK >> 4)) begin
              size_acc = CNT_MASK;
              w.status = ST_OVERFLOW;
            end else begin
              size_acc = ((size_acc << 4) | {60'b0, nib}) & CNT_MASK;
            end
            have_digit = 1'b1;
          end else if (have_digit || digits_end || (b != CH_SPACE && b != CH_TAB)) begin
            // Blanks ahead of the first digit leave the line open for digits.
            digits_end = 1'b1;
          end
          saw_cr = (b == CH_CR);
        end
      end
      PH_DATA, PH_LEN: begin
        w.payload_valid = 1'b1;
        if (left_cnt <= 1) begin
          left_cnt = '0;
          w.chunk_last = 1'b1;
          if (dec_phase == PH_LEN) begin
            dec_phase = PH_DONE;
            w.body_done = 1'b1;
          end else begin
            dec_phase = PH_DATAEND;
          end
        end else begin
          left_cnt = left_cnt - 1;
        end
        saw_cr = 1'b0;
      end
      PH_DATAEND: begin
        if (line_end) begin
          dec_phase = PH_SIZE;
          clear_size_line();
        end else begin
          saw_cr = (b == CH_CR);
        end
      end
      PH_TRAILER: begin
        // In the trailer, digits_end marks a field line that has content.
        if (line_end) begin
          if (!digits_end) begin
            dec_phase = PH_DONE;
            w.body_done = 1'b1;
          end
          clear_size_line();
        end else begin
          if (b != CH_CR || saw_cr) digits_end = 1'b1;
          saw_cr = (b == CH_CR);
        end
      end
      default: begin
        dec_phase = PH_DONE;
        w.body_done = 1'b1;
        w.status = ST_AFTER_END;
      end
    endcase

    if (w.payload_valid) w.out_byte = b;
    w.total_bytes = total_cnt[TOTAL_WIDTH-1:0];
    return w;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Byte sender: takes the next byte from the queue once the previous byte is accepted.
  always @(posedge clk) begin
    body_byte_t nxt;
    if (rst) begin
      in_ch.valid     <= 1'b0;
      in_ch.in_byte   <= '0;
      in_ch.msg_start <= 1'b0;
      src_gap <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (src_gap != 0 || raw_q.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (src_gap != 0) src_gap <= src_gap - 1;
      end else begin
        nxt = raw_q.pop_front();
        in_ch.in_byte   <= nxt.data;
        in_ch.msg_start <= nxt.start;
        in_ch.valid     <= 1'b1;
        src_gap <= idle_on ? pick_gap() : 0;
      end
    end
  end

  // Result sink with random stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      snk_gap <= 0;
    end else if (snk_gap != 0) begin
      out_ch.ready <= 1'b0;
      snk_gap <= snk_gap - 1;
    end else begin
      out_ch.ready <= 1'b1;
      snk_gap <= idle_on ? pick_gap() : 0;
    end
  end

  // Predict on every accepted input word, check every accepted result word.
  always @(posedge clk) begin
    dec_word_t want;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready)
        decoded_q.push_back(decode_byte(in_ch.in_byte, in_ch.msg_start));
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result word: expected none, actual byte %0h status %0d",
                   $time, out_ch.out_byte, out_ch.status);
        end else begin
          want = decoded_q.pop_front();
          check_field("out_byte", want.out_byte, out_ch.out_byte);
          check_field("payload_valid", want.payload_valid, out_ch.payload_valid);
          check_field("chunk_last", want.chunk_last, out_ch.chunk_last);
          check_field("body_done", want.body_done, out_ch.body_done);
          check_field("total_bytes", want.total_bytes, out_ch.total_bytes);
          check_field("status", want.status, out_ch.status);
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic put(input logic [7:0] b);
    raw_q.push_back('{data: b, start: start_next});
    start_next = 1'b0;
    pushed_cnt++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic put_random(input int unsigned n);
    repeat (n) put(8'($urandom_range(0, 255)));
  endtask

  // Size line with optional blanks, case, leading zero and extension text or a stray LF.
  task automatic put_size_line(input logic [31:0] sz);
    string hx;
    int unsigned r;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) put($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    hx = $sformatf("%0h", sz);
    if ($urandom_range(0, 1)) hx = hx.toupper();
    if ($urandom_range(0, 5) == 0) hx = {"0", hx};
    put_text(hx);
    r = $urandom_range(0, 5);
    if (r == 0) put_text(";name=val");
    else if (r == 1) put_text(" ext");
    else if (r == 2) put(CH_LF);
    put_text("\r\n");
  endtask

  // Mostly well-formed chunked body: data chunks, last chunk, trailer, stray bytes after it.
  task automatic put_chunked_body();
    logic [31:0] sz;
    start_next = 1'b1;
    repeat ($urandom_range(0, 3)) begin
      sz = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 12);
      put_size_line(sz);
      put_random(sz);
      if ($urandom_range(0, 4) == 0) put_random($urandom_range(1, 2));
      put_text("\r\n");
    end
    put_size_line(0);
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 1)) put_text("Expires: 0\r\n");
      else put_text("X-Tag: a\r\n");
    end
    put_text("\r\n");
    if ($urandom_range(0, 3) == 0) put_random($urandom_range(1, 3));
  endtask

  // Malformed or cut-off chunked bodies.
  task automatic put_broken_body();
    logic [31:0] sz;
    start_next = 1'b1;
    case ($urandom_range(0, 4))
      0: begin
        if ($urandom_range(0, 1)) put_text("\r\n");
        else put_text(" ;x\r\n");
        put_random($urandom_range(0, 2));
      end
      1: put_text("\n5\r\nabc");
      2: begin
        // Nine or more digits push the size past the counter.
        put_text("1");
        repeat ($urandom_range(8, 10)) put(hexchars[$urandom_range(0, 21)]);
        put_text("\r\n");
        put_random(5);
      end
      3: begin
        sz = $urandom_range(5, 20);
        put_size_line(sz);
        put_random($urandom_range(0, sz - 1));
      end
      default: begin
        put_size_line(3);
        put_random(3);
        put_text("zz\n\r\n0\r\nA\r\r\n\r\n");
      end
    endcase
  endtask

  task automatic put_noise(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 24) == 0) start_next = 1'b1;
      case ($urandom_range(0, 5))
        0: put(hexchars[$urandom_range(0, 21)]);
        1: put(CH_CR);
        2: put(CH_LF);
        3: put(CH_SPACE);
        4: put(CH_TAB);
        default: put(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // Fixed-length body; very long ones are cut short by the next body.
  task automatic put_length_body(input logic [31:0] len);
    int unsigned n;
    start_next = 1'b1;
    if (len == 0) n = $urandom_range(1, 3);
    else if (len > 40) n = $urandom_range(1, 6);
    else n = len + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
    put_random(n);
  endtask

  // Waits until every byte is taken and every result word has come back.
  task automatic wait_idle();
    do @(negedge clk);
    while (raw_q.size() != 0 || in_ch.valid || decoded_q.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_regs(input bit mode, input logic [31:0] len);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CHUNKED_MODE;
    cfg_data  <= {31'b0, mode};
    @(posedge clk);
    cfg_index <= REG_CONTENT_LENGTH;
    cfg_data  <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    cur_chunked = mode;
    cur_len = len;
  endtask

  initial begin
    int unsigned r;
    logic [31:0] len_sel;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_CHUNKED_MODE;
    cfg_data = '0;
    cur_chunked = 1'b1;
    cur_len = '0;
    dec_phase = PH_SIZE;
    left_cnt = '0;
    total_cnt = '0;
    clear_size_line();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Chunked parsing straight out of reset, no start mark, then a byte past the end.
    put_text("1\r\n");
    put(8'hFF);
    put_text("\r\n0\r\n\r\n");
    put(8'h00);
    wait_idle();
    // Zero length: the start byte already lies past the body.
    write_regs(1'b0, 32'h0);
    start_next = 1'b1;
    put(8'h41);
    wait_idle();
    write_regs(1'b0, 32'hFFFF_FFFF);
    start_next = 1'b1;
    put(8'h00);
    put(8'hFF);
    wait_idle();
    write_regs(1'b0, 32'h1);
    start_next = 1'b1;
    put(8'h7E);
    put(8'h01);
    wait_idle();
    // Size line with no digit, then a size that overflows the counter.
    write_regs(1'b1, 32'h0);
    start_next = 1'b1;
    put_text("\r\n");
    start_next = 1'b1;
    put_text("FFFFFFFFF");

    // Random bodies, mostly well formed.
    while (pushed_cnt < 1680) begin
      r = $urandom_range(0, 99);
      if (r < 18) begin
        wait_idle();
        case ($urandom_range(0, 19))
          0: len_sel = 32'h0;
          1: len_sel = 32'hFFFF_FFFF;
          2: len_sel = $urandom;
          default: len_sel = $urandom_range(1, 24);
        endcase
        write_regs(1'b0, len_sel);
        put_length_body(len_sel);
      end else begin
        if (!cur_chunked) begin
          wait_idle();
          write_regs(1'b1, $urandom);
        end
        if (r < 75) put_chunked_body();
        else if (r < 90) put_broken_body();
        else put_noise($urandom_range(3, 12));
      end
      if ($urandom_range(0, 9) == 0) begin
        wait_idle();
        idle_on = ($urandom_range(0, 3) != 0);
      end
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (err_cnt == 0 && decoded_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
hw/rtl/hcbd_pkg.sv
hw/rtl/hcbd_channels.sv
hw/rtl/http_chunked_body_decoder.sv
tb/sv/tb.sv
